>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the HPACK encoder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, masked during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// property checked on the next clock after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/hpack_pkg.sv
// Package for the HPACK Huffman encoder: code table and shared types.
// No dependencies.
package hpack_pkg;

   localparam int unsigned CodeW = 30;
   localparam int unsigned LenW  = 5;
   localparam int unsigned AccW  = 40;

   typedef struct packed {
      logic [CodeW-1:0] code;
      logic [LenW-1:0]  len;
   } huff_entry_type;

   // beat group produced by one input item: up to five bytes
   typedef struct packed {
      logic [39:0] bytes;
      logic [2:0]  count;
      logic        string_end;
   } burst_type;

   function automatic logic [CodeW-1:0] code_of(input logic [7:0] s);
      logic [CodeW-1:0] c;
      c = '0;
      case (s)
         8'd0: c = 30'h1ff8; 8'd1: c = 30'h7fffd8; 8'd2: c = 30'hfffffe2;
         8'd3: c = 30'hfffffe3; 8'd4: c = 30'hfffffe4; 8'd5: c = 30'hfffffe5;
         8'd6: c = 30'hfffffe6; 8'd7: c = 30'hfffffe7; 8'd8: c = 30'hfffffe8;
         8'd9: c = 30'hffffea; 8'd10: c = 30'h3ffffffc; 8'd11: c = 30'hfffffe9;
         8'd12: c = 30'hfffffea; 8'd13: c = 30'h3ffffffd; 8'd14: c = 30'hfffffeb;
         8'd15: c = 30'hfffffec; 8'd16: c = 30'hfffffed; 8'd17: c = 30'hfffffee;
         8'd18: c = 30'hfffffef; 8'd19: c = 30'hffffff0; 8'd20: c = 30'hffffff1;
         8'd21: c = 30'hffffff2; 8'd22: c = 30'h3ffffffe; 8'd23: c = 30'hffffff3;
         8'd24: c = 30'hffffff4; 8'd25: c = 30'hffffff5; 8'd26: c = 30'hffffff6;
         8'd27: c = 30'hffffff7; 8'd28: c = 30'hffffff8; 8'd29: c = 30'hffffff9;
         8'd30: c = 30'hffffffa; 8'd31: c = 30'hffffffb; 8'd32: c = 30'h14;
         8'd33: c = 30'h3f8; 8'd34: c = 30'h3f9; 8'd35: c = 30'hffa;
         8'd36: c = 30'h1ff9; 8'd37: c = 30'h15; 8'd38: c = 30'hf8;
         8'd39: c = 30'h7fa; 8'd40: c = 30'h3fa; 8'd41: c = 30'h3fb;
         8'd42: c = 30'hf9; 8'd43: c = 30'h7fb; 8'd44: c = 30'hfa;
         8'd45: c = 30'h16; 8'd46: c = 30'h17; 8'd47: c = 30'h18;
         8'd48: c = 30'h0; 8'd49: c = 30'h1; 8'd50: c = 30'h2;
         8'd51: c = 30'h19; 8'd52: c = 30'h1a; 8'd53: c = 30'h1b;
         8'd54: c = 30'h1c; 8'd55: c = 30'h1d; 8'd56: c = 30'h1e;
         8'd57: c = 30'h1f; 8'd58: c = 30'h5c; 8'd59: c = 30'hfb;
         8'd60: c = 30'h7ffc; 8'd61: c = 30'h20; 8'd62: c = 30'hffb;
         8'd63: c = 30'h3fc; 8'd64: c = 30'h1ffa; 8'd65: c = 30'h21;
         8'd66: c = 30'h5d; 8'd67: c = 30'h5e; 8'd68: c = 30'h5f;
         8'd69: c = 30'h60; 8'd70: c = 30'h61; 8'd71: c = 30'h62;
         8'd72: c = 30'h63; 8'd73: c = 30'h64; 8'd74: c = 30'h65;
         8'd75: c = 30'h66; 8'd76: c = 30'h67; 8'd77: c = 30'h68;
         8'd78: c = 30'h69; 8'd79: c = 30'h6a; 8'd80: c = 30'h6b;
         8'd81: c = 30'h6c; 8'd82: c = 30'h6d; 8'd83: c = 30'h6e;
         8'd84: c = 30'h6f; 8'd85: c = 30'h70; 8'd86: c = 30'h71;
         8'd87: c = 30'h72; 8'd88: c = 30'hfc; 8'd89: c = 30'h73;
         8'd90: c = 30'hfd; 8'd91: c = 30'h1ffb; 8'd92: c = 30'h7fff0;
         8'd93: c = 30'h1ffc; 8'd94: c = 30'h3ffc; 8'd95: c = 30'h22;
         8'd96: c = 30'h7ffd; 8'd97: c = 30'h3; 8'd98: c = 30'h23;
         8'd99: c = 30'h4; 8'd100: c = 30'h24; 8'd101: c = 30'h5;
         8'd102: c = 30'h25; 8'd103: c = 30'h26; 8'd104: c = 30'h27;
         8'd105: c = 30'h6; 8'd106: c = 30'h74; 8'd107: c = 30'h75;
         8'd108: c = 30'h28; 8'd109: c = 30'h29; 8'd110: c = 30'h2a;
         8'd111: c = 30'h7; 8'd112: c = 30'h2b; 8'd113: c = 30'h76;
         8'd114: c = 30'h2c; 8'd115: c = 30'h8; 8'd116: c = 30'h9;
         8'd117: c = 30'h2d; 8'd118: c = 30'h77; 8'd119: c = 30'h78;
         8'd120: c = 30'h79; 8'd121: c = 30'h7a; 8'd122: c = 30'h7b;
         8'd123: c = 30'h7ffe; 8'd124: c = 30'h7fc; 8'd125: c = 30'h3ffd;
         8'd126: c = 30'h1ffd; 8'd127: c = 30'hffffffc; 8'd128: c = 30'hfffe6;
         8'd129: c = 30'h3fffd2; 8'd130: c = 30'hfffe7; 8'd131: c = 30'hfffe8;
         8'd132: c = 30'h3fffd3; 8'd133: c = 30'h3fffd4; 8'd134: c = 30'h3fffd5;
         8'd135: c = 30'h7fffd9; 8'd136: c = 30'h3fffd6; 8'd137: c = 30'h7fffda;
         8'd138: c = 30'h7fffdb; 8'd139: c = 30'h7fffdc; 8'd140: c = 30'h7fffdd;
         8'd141: c = 30'h7fffde; 8'd142: c = 30'hffffeb; 8'd143: c = 30'h7fffdf;
         8'd144: c = 30'hffffec; 8'd145: c = 30'hffffed; 8'd146: c = 30'h3fffd7;
         8'd147: c = 30'h7fffe0; 8'd148: c = 30'hffffee; 8'd149: c = 30'h7fffe1;
         8'd150: c = 30'h7fffe2; 8'd151: c = 30'h7fffe3; 8'd152: c = 30'h7fffe4;
         8'd153: c = 30'h1fffdc; 8'd154: c = 30'h3fffd8; 8'd155: c = 30'h7fffe5;
         8'd156: c = 30'h3fffd9; 8'd157: c = 30'h7fffe6; 8'd158: c = 30'h7fffe7;
         8'd159: c = 30'hffffef; 8'd160: c = 30'h3fffda; 8'd161: c = 30'h1fffdd;
         8'd162: c = 30'hfffe9; 8'd163: c = 30'h3fffdb; 8'd164: c = 30'h3fffdc;
         8'd165: c = 30'h7fffe8; 8'd166: c = 30'h7fffe9; 8'd167: c = 30'h1fffde;
         8'd168: c = 30'h7fffea; 8'd169: c = 30'h3fffdd; 8'd170: c = 30'h3fffde;
         8'd171: c = 30'hfffff0; 8'd172: c = 30'h1fffdf; 8'd173: c = 30'h3fffdf;
         8'd174: c = 30'h7fffeb; 8'd175: c = 30'h7fffec; 8'd176: c = 30'h1fffe0;
         8'd177: c = 30'h1fffe1; 8'd178: c = 30'h3fffe0; 8'd179: c = 30'h1fffe2;
         8'd180: c = 30'h7fffed; 8'd181: c = 30'h3fffe1; 8'd182: c = 30'h7fffee;
         8'd183: c = 30'h7fffef; 8'd184: c = 30'hfffea; 8'd185: c = 30'h3fffe2;
         8'd186: c = 30'h3fffe3; 8'd187: c = 30'h3fffe4; 8'd188: c = 30'h7ffff0;
         8'd189: c = 30'h3fffe5; 8'd190: c = 30'h3fffe6; 8'd191: c = 30'h7ffff1;
         8'd192: c = 30'h3ffffe0; 8'd193: c = 30'h3ffffe1; 8'd194: c = 30'hfffeb;
         8'd195: c = 30'h7fff1; 8'd196: c = 30'h3fffe7; 8'd197: c = 30'h7ffff2;
         8'd198: c = 30'h3fffe8; 8'd199: c = 30'h1ffffec; 8'd200: c = 30'h3ffffe2;
         8'd201: c = 30'h3ffffe3; 8'd202: c = 30'h3ffffe4; 8'd203: c = 30'h7ffffde;
         8'd204: c = 30'h7ffffdf; 8'd205: c = 30'h3ffffe5; 8'd206: c = 30'hfffff1;
         8'd207: c = 30'h1ffffed; 8'd208: c = 30'h7fff2; 8'd209: c = 30'h1fffe3;
         8'd210: c = 30'h3ffffe6; 8'd211: c = 30'h7ffffe0; 8'd212: c = 30'h7ffffe1;
         8'd213: c = 30'h3ffffe7; 8'd214: c = 30'h7ffffe2; 8'd215: c = 30'hfffff2;
         8'd216: c = 30'h1fffe4; 8'd217: c = 30'h1fffe5; 8'd218: c = 30'h3ffffe8;
         8'd219: c = 30'h3ffffe9; 8'd220: c = 30'hffffffd; 8'd221: c = 30'h7ffffe3;
         8'd222: c = 30'h7ffffe4; 8'd223: c = 30'h7ffffe5; 8'd224: c = 30'hfffec;
         8'd225: c = 30'hfffff3; 8'd226: c = 30'hfffed; 8'd227: c = 30'h1fffe6;
         8'd228: c = 30'h3fffe9; 8'd229: c = 30'h1fffe7; 8'd230: c = 30'h1fffe8;
         8'd231: c = 30'h7ffff3; 8'd232: c = 30'h3fffea; 8'd233: c = 30'h3fffeb;
         8'd234: c = 30'h1ffffee; 8'd235: c = 30'h1ffffef; 8'd236: c = 30'hfffff4;
         8'd237: c = 30'hfffff5; 8'd238: c = 30'h3ffffea; 8'd239: c = 30'h7ffff4;
         8'd240: c = 30'h3ffffeb; 8'd241: c = 30'h7ffffe6; 8'd242: c = 30'h3ffffec;
         8'd243: c = 30'h3ffffed; 8'd244: c = 30'h7ffffe7; 8'd245: c = 30'h7ffffe8;
         8'd246: c = 30'h7ffffe9; 8'd247: c = 30'h7ffffea; 8'd248: c = 30'h7ffffeb;
         8'd249: c = 30'hffffffe; 8'd250: c = 30'h7ffffec; 8'd251: c = 30'h7ffffed;
         8'd252: c = 30'h7ffffee; 8'd253: c = 30'h7ffffef; 8'd254: c = 30'h7fffff0;
         default: c = 30'h3ffffee;
      endcase
      return c;
   endfunction

   // code length: largest set bit plus one does not hold for the zero
   // codes, so lengths are tabulated per row of 16
   function automatic logic [LenW-1:0] len_of(input logic [7:0] s);
      int unsigned lens [256];
      lens = '{
         13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
         28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
         6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
         5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
         13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
         7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
         15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
         6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
         20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
         24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
         22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
         21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
         26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
         19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
         20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
         26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26};
      return LenW'(lens[s]);
   endfunction

endpackage

>>> rtl/core/hpack_pack.sv
// Bit packer: appends one Huffman code to the pending bits and forms the
// beat group for one item. Depends on hpack_pkg.
module hpack_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                symbol,
   input  logic                      string_end,
   output hpack_pkg::burst_type      burst
);

   logic [6:0]  pend_ff, pend_in;
   logic [2:0]  pcnt_ff, pcnt_in;
   logic [hpack_pkg::LenW-1:0]  len;
   logic [hpack_pkg::CodeW-1:0] code;
   logic [5:0]  total;
   logic [hpack_pkg::AccW-1:0]  acc, left;
   logic [2:0]  full;
   logic [2:0]  rem;

   // code lookup, merge with pending bits, left-align in a 40-bit window
   always_comb begin
      code  = hpack_pkg::code_of(symbol);
      len   = hpack_pkg::len_of(symbol);
      total = 6'(pcnt_ff) + 6'(len);
      acc   = (40'(pend_ff) << len) | 40'(code);
      left  = acc << (6'd40 - total);
      full  = total[5:3];
      rem   = total[2:0];
      // ones fill below the valid bits for the padded byte
      burst.bytes = left | (string_end ? ({40{1'b1}} >> total) : '0);
      burst.count = full + 3'((string_end && rem != 3'd0) ? 1 : 0);
      burst.string_end = string_end;
      pend_in = string_end ? 7'd0 : 7'(acc & ((40'd1 << rem) - 40'd1));
      pcnt_in = string_end ? 3'd0 : rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pcnt_ff <= '0;
      end else if (step) begin
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
      end
   end

endmodule

>>> rtl/core/hpack_emit.sv
// Output serializer: holds one beat group and sends its bytes one per
// beat. Depends on hpack_pkg.
module hpack_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hpack_pkg::burst_type burst,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_coded_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_coded_end
);

   logic [39:0] bytes_ff, bytes_in;
   logic [2:0]  left_ff, left_in;
   logic        end_ff, end_in;
   logic        take;

   assign take = rsp_valid && rsp_ready;
   // free when empty or on the final byte being taken
   assign free = (left_ff == 3'd0) || (left_ff == 3'd1 && rsp_ready);

   always_comb begin
      bytes_in = bytes_ff;
      left_in  = left_ff;
      end_in   = end_ff;
      if (take) begin
         bytes_in = bytes_ff << 8;
         left_in  = left_ff - 3'd1;
      end
      if (load) begin
         bytes_in = burst.bytes;
         left_in  = burst.count;
         end_in   = burst.string_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      bytes_ff <= bytes_in;
      end_ff   <= end_in;
   end

   assign rsp_valid      = left_ff != 3'd0;
   assign rsp_coded_byte = bytes_ff[39:32];
   assign rsp_run_last   = left_ff == 3'd1;
   assign rsp_coded_end  = left_ff == 3'd1 && end_ff;

endmodule

>>> rtl/core/hpack_huffman_encoder.sv
// HPACK Huffman encoder top level. An item's first byte, if any, is valid
// in the cycle after its input beat. Throughput: one item per cycle if it
// yields at most one byte and rsp_ready is high; else the next item waits
// for the last byte (up to 5) to leave the single-byte result port. Reset
// (synchronous, active-high) clears the pending bits and the output queue.
// Depends on hpack_pkg, hpack_pack, hpack_emit and assert_macros.svh.
`include "assert_macros.svh"
module hpack_huffman_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_coded_byte,
   output logic       rsp_run_last,
   output logic       rsp_coded_end
);

   hpack_pkg::burst_type burst;
   logic free;
   logic step;

   assign req_ready = free;
   assign step      = req_valid && req_ready;

   hpack_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .symbol     (req_symbol),
      .string_end (req_string_end),
      .burst      (burst)
   );

   hpack_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (step),
      .burst          (burst),
      .free           (free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coded_byte (rsp_coded_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_coded_end  (rsp_coded_end)
   );

   // an end-marked item always yields at least one byte
   `ASSERT_NEXT(a_end_yields, clock, reset, step && req_string_end, rsp_valid)
   // the end flag only rides on the last byte of a run
   `ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && rsp_coded_end, rsp_run_last)

endmodule
